/* rtl/tslfo_pkg.sv */
// ----------------------------------------------------------------------------
// tslfo_pkg: shared definitions of the tempo-synced LFO
// Types, register indexes, fixed-point widths and the sine polynomial
// coefficients used by the LFO sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tslfo_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int BEAT_FRAC_BITS = 24;
    localparam int BEAT_BITS      = 48;
    localparam int LEVEL_BITS     = 24;
    localparam int DIV_NUM_BITS   = 56;
    localparam int DIV_DEN_BITS   = 35;
    localparam int CFG_DATA_BITS  = 18;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_LFO_SYNC      = 3'd0;
    localparam logic [2:0] CFG_RATE_DIVISION = 3'd1;
    localparam logic [2:0] CFG_WAVE_SHAPE    = 3'd2;
    localparam logic [2:0] CFG_FREE_RATE     = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_RATE   = 3'd4;
    localparam logic [2:0] CFG_COEF_NORMAL   = 3'd5;
    localparam logic [2:0] CFG_COEF_SQUARE   = 3'd6;

    // Waveform codes.
    localparam logic [2:0] SHAPE_SINE     = 3'd0;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
    localparam logic [2:0] SHAPE_FALLING  = 3'd2;
    localparam logic [2:0] SHAPE_RISING   = 3'd3;
    localparam logic [2:0] SHAPE_SQUARE   = 3'd4;

    // Item kinds carried in tuser.
    localparam logic CMD_TRANSPORT = 1'b0;
    localparam logic CMD_TICK      = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_PREP2, ST_LOAD, ST_DIV, ST_DIVEND, ST_WAVE,
        ST_SIN_SQ, ST_SIN_X2, ST_SIN_MUL, ST_SIN_ACC, ST_SIN_FIN, ST_SIN_Y,
        ST_SMOOTH, ST_ACC, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_PHASE, DIV_BEAT, DIV_FREE_SYNC, DIV_FREE
    } t_div;

    // Q28 coefficients of the odd Taylor series of sin(pi/2 * x).
    function automatic logic [29:0] sin_coef(input logic [2:0] idx);
        logic [29:0] c;
        unique case (idx)
            3'd0:    c = 30'd421657428;
            3'd1:    c = 30'd173399667;
            3'd2:    c = 30'd21392326;
            3'd3:    c = 30'd1256749;
            default: c = 30'd43068;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/tempo_synced_lfo.sv */
// ----------------------------------------------------------------------------
// tempo_synced_lfo: tempo-synced low-frequency oscillator
// Per-sample LFO locked to host transport or free running, with sine,
// triangle, saw and square shapes and a one-pole output smoother.
// ----------------------------------------------------------------------------
`default_nettype none

// An input transfer with tuser low is a transport snapshot: it is absorbed in
// the idle state and gives no result. An input transfer with tuser high is a
// sample tick and gives exactly one result. A tick is worked out by a small
// sequencer around one shared bit-serial divider (one quotient bit per cycle,
// with a load step before and an end step after each division) and one shared
// 30x30 multiplier used for the sine polynomial. With sync off a tick runs
// one division, the free-step division; in sync mode it runs two: the phase
// and beat-step divisions with a usable transport, and the beat-step and
// free-step divisions with an unusable one. The sine shape adds the polynomial
// steps to either path. The sequencer returns to idle before the next input
// is taken, and the output step waits for as long as an earlier result is
// still held in the output register. The input is not ready while a tick is
// being worked on; a finished result sits in the output register, so the next
// item may be taken while it waits.

module tempo_synced_lfo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [17:0] i_cfg_data,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0: transport_valid, transport_playing, host_bpm[13:0],
    // host_beats_per_bar[9:0], bar_index[15:0], beat_in_bar[21:0]
    input  wire logic [63:0] s_axis_tdata,
    // tuser: cmd (0 transport snapshot, 1 sample tick)
    input  wire logic        s_axis_tuser,
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0: bipolar_level[15:0], unipolar_level[15:0], synced,
    // seven zero bits
    output logic [39:0]      m_axis_tdata
);

    // Configuration registers.
    logic        r_lfo_sync;
    logic [2:0]  r_rate_div;
    logic [2:0]  r_wave_shape;
    logic [14:0] r_free_rate;
    logic [17:0] r_sample_rate;
    logic [15:0] r_coef_norm;
    logic [15:0] r_coef_sq;

    // Oscillator state.
    logic [47:0]        r_beat_pos;
    logic [13:0]        r_tempo;
    logic [9:0]         r_bar_len;
    logic               r_transport_ok;
    logic [31:0]        r_free_phase;
    logic signed [23:0] r_smooth;

    // Working registers of one tick.
    tslfo_pkg::t_state r_state, n_state;
    tslfo_pkg::t_div   r_div;
    logic [17:0]        r_sr;
    logic [12:0]        r_tclamp;
    logic [14:0]        r_rclamp;
    logic [12:0]        r_d;
    logic [30:0]        r_srd;
    logic [31:0]        r_phase;
    logic [55:0]        r_num;
    logic [34:0]        r_den;
    logic [34:0]        r_rem;
    logic [5:0]         r_cnt;
    logic [28:0]        r_x;
    logic [1:0]         r_quad;
    logic [28:0]        r_x2;
    logic [29:0]        r_acc;
    logic [2:0]         r_cidx;
    logic [59:0]        r_mprod;
    logic signed [23:0] r_target;
    logic               r_is_square;
    logic signed [41:0] r_sprod;
    logic               r_m_valid;
    logic [39:0]        r_m_data;

    // Transport fields.
    logic        w_tv, w_tp;
    logic [13:0] w_bpm;
    logic [9:0]  w_bpb;
    logic [15:0] w_bar;
    logic [21:0] w_beat;
    assign w_tv   = s_axis_tdata[0];
    assign w_tp   = s_axis_tdata[1];
    assign w_bpm  = s_axis_tdata[15:2];
    assign w_bpb  = s_axis_tdata[25:16];
    assign w_bar  = s_axis_tdata[41:26];
    assign w_beat = s_axis_tdata[63:42];

    logic w_in_acc;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Beat position loaded from a usable snapshot.
    logic [9:0]  w_load_len;
    logic [25:0] w_bar_beats;
    logic [47:0] w_load_pos;
    logic        w_bpm_ok, w_bpb_ok;
    assign w_bpm_ok    = (w_bpm > 14'd16);
    assign w_bpb_ok    = (w_bpb != 10'd0);
    assign w_load_len  = (w_bpb < 10'd16) ? 10'd16 : w_bpb;
    assign w_bar_beats = 26'(w_bar * w_load_len);
    assign w_load_pos  = {2'b0, w_bar_beats, 20'b0} + {18'b0, w_beat, 8'b0};

    // Cycle length in 96ths of a beat.
    logic [9:0]  w_len;
    logic [12:0] w_d;
    logic [12:0] w_len3;
    assign w_len  = (r_bar_len < 10'd16) ? 10'd16 : r_bar_len;
    assign w_len3 = 13'(w_len * 2'd3);
    always_comb begin
        unique case (r_rate_div)
            3'd0:    w_d = 13'(w_len * 3'd6);
            3'd1:    w_d = (w_len3 < 13'd48) ? 13'd48 : w_len3;
            3'd2:    w_d = 13'd96;
            3'd3:    w_d = 13'd48;
            3'd4:    w_d = 13'd32;
            3'd5:    w_d = 13'd24;
            3'd6:    w_d = 13'd16;
            default: w_d = 13'd12;
        endcase
    end

    // Divider step: one quotient bit per cycle, quotient shifts into r_num.
    logic [35:0] w_rem_sh;
    logic        w_ge;
    assign w_rem_sh = {r_rem, r_num[55]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    // Shape selection: codes above square act as square.
    logic [2:0] w_shape;
    assign w_shape = (r_wave_shape > tslfo_pkg::SHAPE_SQUARE) ? tslfo_pkg::SHAPE_SQUARE
                                                               : r_wave_shape;

    // Plain waveforms on a 22-bit phase fraction.
    logic [21:0]        w_f;
    logic signed [25:0] w_f26;
    logic signed [25:0] w_wave;
    assign w_f   = r_phase[31:10];
    assign w_f26 = signed'({4'b0, w_f});
    always_comb begin
        unique case (w_shape)
            tslfo_pkg::SHAPE_TRIANGLE:
                w_wave = (w_f[21] == 1'b0) ? (26'sd4 * w_f26 - 26'sd4194304)
                                           : (26'sd12582912 - 26'sd4 * w_f26);
            tslfo_pkg::SHAPE_FALLING: w_wave = 26'sd4194304 - 26'sd2 * w_f26;
            tslfo_pkg::SHAPE_RISING:  w_wave = 26'sd2 * w_f26 - 26'sd4194304;
            default:
                w_wave = (w_f[21] == 1'b0) ? 26'sd4194304 : -26'sd4194304;
        endcase
    end

    // Sine argument on the quarter wave, from the top ten phase bits.
    logic [9:0]  w_k;
    logic [28:0] w_xq;
    assign w_k  = r_phase[31:22];
    assign w_xq = w_k[8] ? (29'h1000_0000 - {1'b0, w_k[7:0], 20'b0})
                         : {1'b0, w_k[7:0], 20'b0};

    // Shared multiplier.
    logic [29:0] w_mul_a, w_mul_b;
    logic [59:0] w_mul_p;
    assign w_mul_p = w_mul_a * w_mul_b;

    // Sine output from the final product.
    logic [32:0] w_y_sum;
    logic [23:0] w_y;
    logic [23:0] w_y_lim;
    assign w_y_sum = {1'b0, r_mprod[59:28]} + 33'd32;
    assign w_y     = w_y_sum[29:6];
    assign w_y_lim = (w_y > 24'd4194304) ? 24'd4194304 : w_y;

    // Smoother update and output scaling.
    logic signed [24:0] w_diff;
    logic signed [41:0] w_sround;
    logic signed [24:0] w_sb;
    logic signed [17:0] w_b;
    logic [15:0]        w_bip;
    assign w_diff   = 25'(r_target) - 25'(r_smooth);
    assign w_sround = (r_sprod + 42'sd32768) >>> 16;
    assign w_sb     = (25'(r_smooth) + 25'sd64) >>> 7;
    assign w_b      = w_sb[17:0];
    assign w_bip    = (w_b > 18'sd32767)  ? 16'h7FFF :
                      (w_b < -18'sd32768) ? 16'h8000 : w_b[15:0];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tslfo_pkg::ST_IDLE:
                if (w_in_acc && s_axis_tuser == tslfo_pkg::CMD_TICK) begin
                    n_state = tslfo_pkg::ST_PREP;
                end
            tslfo_pkg::ST_PREP:  n_state = tslfo_pkg::ST_PREP2;
            tslfo_pkg::ST_PREP2: n_state = tslfo_pkg::ST_LOAD;
            tslfo_pkg::ST_LOAD:  n_state = tslfo_pkg::ST_DIV;
            tslfo_pkg::ST_DIV:
                if (r_cnt == 6'(tslfo_pkg::DIV_NUM_BITS - 1)) begin
                    n_state = tslfo_pkg::ST_DIVEND;
                end
            tslfo_pkg::ST_DIVEND:
                if (r_div == tslfo_pkg::DIV_PHASE
                    || (r_div == tslfo_pkg::DIV_BEAT && !r_transport_ok)) begin
                    n_state = tslfo_pkg::ST_LOAD;
                end else begin
                    n_state = tslfo_pkg::ST_WAVE;
                end
            tslfo_pkg::ST_WAVE:
                n_state = (w_shape == tslfo_pkg::SHAPE_SINE) ? tslfo_pkg::ST_SIN_SQ
                                                             : tslfo_pkg::ST_SMOOTH;
            tslfo_pkg::ST_SIN_SQ:  n_state = tslfo_pkg::ST_SIN_X2;
            tslfo_pkg::ST_SIN_X2:  n_state = tslfo_pkg::ST_SIN_MUL;
            tslfo_pkg::ST_SIN_MUL: n_state = tslfo_pkg::ST_SIN_ACC;
            tslfo_pkg::ST_SIN_ACC:
                n_state = (r_cidx == 3'd0) ? tslfo_pkg::ST_SIN_FIN : tslfo_pkg::ST_SIN_MUL;
            tslfo_pkg::ST_SIN_FIN: n_state = tslfo_pkg::ST_SIN_Y;
            tslfo_pkg::ST_SIN_Y:   n_state = tslfo_pkg::ST_SMOOTH;
            tslfo_pkg::ST_SMOOTH:  n_state = tslfo_pkg::ST_ACC;
            tslfo_pkg::ST_ACC:     n_state = tslfo_pkg::ST_OUT;
            tslfo_pkg::ST_OUT:
                if (!r_m_valid || m_axis_tready) begin
                    n_state = tslfo_pkg::ST_IDLE;
                end
            default: n_state = tslfo_pkg::ST_IDLE;
        endcase
    end

    // Output and operand selection.
    always_comb begin
        s_axis_tready = (r_state == tslfo_pkg::ST_IDLE);
        unique case (r_state)
            tslfo_pkg::ST_SIN_SQ:  begin w_mul_a = {1'b0, r_x}; w_mul_b = {1'b0, r_x};  end
            tslfo_pkg::ST_SIN_MUL: begin w_mul_a = r_acc;       w_mul_b = {1'b0, r_x2}; end
            default:               begin w_mul_a = r_acc;       w_mul_b = {1'b0, r_x};  end
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tslfo_pkg::ST_IDLE;
            r_lfo_sync     <= 1'b0;
            r_rate_div     <= 3'd2;
            r_wave_shape   <= tslfo_pkg::SHAPE_SINE;
            r_free_rate    <= 15'd1000;
            r_sample_rate  <= 18'd48000;
            r_coef_norm    <= 16'd1083;
            r_coef_sq      <= 16'd303;
            r_beat_pos     <= '0;
            r_tempo        <= 14'd1920;
            r_bar_len      <= 10'd64;
            r_transport_ok <= 1'b0;
            r_free_phase   <= '0;
            r_smooth       <= '0;
            r_m_valid      <= 1'b0;
            r_div          <= tslfo_pkg::DIV_BEAT;
            r_cnt          <= '0;
            r_cidx         <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tslfo_pkg::CFG_LFO_SYNC:      r_lfo_sync    <= i_cfg_data[0];
                    tslfo_pkg::CFG_RATE_DIVISION: r_rate_div    <= i_cfg_data[2:0];
                    tslfo_pkg::CFG_WAVE_SHAPE:    r_wave_shape  <= i_cfg_data[2:0];
                    tslfo_pkg::CFG_FREE_RATE:     r_free_rate   <= i_cfg_data[14:0];
                    tslfo_pkg::CFG_SAMPLE_RATE:   r_sample_rate <= i_cfg_data;
                    tslfo_pkg::CFG_COEF_NORMAL:   r_coef_norm   <= i_cfg_data[15:0];
                    tslfo_pkg::CFG_COEF_SQUARE:   r_coef_sq     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // A new result is loaded from the output step once the register
            // is free; otherwise a taken result empties it.
            if (r_state == tslfo_pkg::ST_OUT && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                tslfo_pkg::ST_IDLE:
                    if (w_in_acc && s_axis_tuser == tslfo_pkg::CMD_TRANSPORT) begin
                        if (w_bpm_ok) r_tempo <= w_bpm;
                        if (w_bpb_ok) r_bar_len <= w_bpb;
                        r_transport_ok <= w_tv && w_tp && w_bpm_ok && w_bpb_ok;
                        if (w_tv && w_tp && w_bpm_ok && w_bpb_ok) begin
                            r_beat_pos <= w_load_pos;
                        end
                    end
                tslfo_pkg::ST_PREP: begin
                    r_sr     <= (r_sample_rate < 18'd1000) ? 18'd1000 : r_sample_rate;
                    r_tclamp <= (r_tempo < 14'd320)  ? 13'd320 :
                                (r_tempo > 14'd5120) ? 13'd5120 : r_tempo[12:0];
                    r_rclamp <= (r_free_rate < 15'd50)    ? 15'd50 :
                                (r_free_rate > 15'd20000) ? 15'd20000 : r_free_rate;
                    r_d      <= w_d;
                    r_phase  <= r_free_phase;
                end
                tslfo_pkg::ST_PREP2: begin
                    r_srd <= 31'(r_sr * r_d);
                    if (!r_lfo_sync) begin
                        r_div <= tslfo_pkg::DIV_FREE;
                    end else if (r_transport_ok) begin
                        r_div <= tslfo_pkg::DIV_PHASE;
                    end else begin
                        r_div <= tslfo_pkg::DIV_BEAT;
                    end
                end
                tslfo_pkg::ST_LOAD: begin
                    r_rem <= '0;
                    r_cnt <= '0;
                    unique case (r_div)
                        tslfo_pkg::DIV_PHASE: begin
                            r_num <= {2'b0, r_beat_pos, 6'b0} + {3'b0, r_beat_pos, 5'b0};
                            r_den <= {22'b0, r_d};
                        end
                        tslfo_pkg::DIV_BEAT: begin
                            r_num <= {19'b0, r_tclamp, 24'b0};
                            r_den <= 35'(r_sr * 10'd960);
                        end
                        tslfo_pkg::DIV_FREE_SYNC: begin
                            r_num <= {11'b0, r_tclamp, 32'b0};
                            r_den <= 35'({4'b0, r_srd} * 35'd10);
                        end
                        default: begin
                            r_num <= {9'b0, r_rclamp, 32'b0};
                            r_den <= 35'(r_sr * 10'd1000);
                        end
                    endcase
                end
                tslfo_pkg::ST_DIV: begin
                    r_rem <= w_ge ? 35'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[34:0];
                    r_num <= {r_num[54:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                end
                tslfo_pkg::ST_DIVEND:
                    unique case (r_div)
                        tslfo_pkg::DIV_PHASE: begin
                            // Low 24 quotient bits are the fraction of the cycle.
                            r_phase <= {r_num[23:0], 8'b0};
                            r_div   <= tslfo_pkg::DIV_BEAT;
                        end
                        tslfo_pkg::DIV_BEAT: begin
                            r_beat_pos <= r_beat_pos + r_num[47:0];
                            r_div      <= tslfo_pkg::DIV_FREE_SYNC;
                        end
                        default: r_free_phase <= r_free_phase + r_num[31:0];
                    endcase
                tslfo_pkg::ST_WAVE: begin
                    r_target    <= w_wave[23:0];
                    r_is_square <= (w_shape == tslfo_pkg::SHAPE_SQUARE);
                    r_x         <= w_xq;
                    r_quad      <= w_k[9:8];
                end
                tslfo_pkg::ST_SIN_SQ:  r_mprod <= w_mul_p;
                tslfo_pkg::ST_SIN_X2: begin
                    r_x2   <= r_mprod[56:28];
                    r_acc  <= tslfo_pkg::sin_coef(3'd4);
                    r_cidx <= 3'd3;
                end
                tslfo_pkg::ST_SIN_MUL: r_mprod <= w_mul_p;
                tslfo_pkg::ST_SIN_ACC: begin
                    r_acc <= tslfo_pkg::sin_coef(r_cidx) - r_mprod[57:28];
                    if (r_cidx != 3'd0) r_cidx <= r_cidx - 3'd1;
                end
                tslfo_pkg::ST_SIN_FIN: r_mprod <= w_mul_p;
                tslfo_pkg::ST_SIN_Y:
                    r_target <= r_quad[1] ? -signed'(w_y_lim) : signed'(w_y_lim);
                tslfo_pkg::ST_SMOOTH:
                    r_sprod <= w_diff * signed'({1'b0,
                                   (r_is_square ? r_coef_sq : r_coef_norm)});
                tslfo_pkg::ST_ACC:
                    r_smooth <= r_smooth + w_sround[23:0];
                tslfo_pkg::ST_OUT:
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= {7'b0, r_lfo_sync && r_transport_ok,
                                      ~w_bip[15], w_bip[14:0], w_bip};
                    end
                default: ;
            endcase
        end
    end

    // The divider never runs past its last quotient bit.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tslfo_pkg::ST_DIV |-> r_cnt <= 6'(tslfo_pkg::DIV_NUM_BITS - 1))
        else $error("divider count overrun");

    // A new result is only ever presented from the output step.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == tslfo_pkg::ST_OUT)
        else $error("result raised outside output step");

    // The smoother stays within the waveform range.
    a_smooth_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_smooth <= 24'sd4194304 && r_smooth >= -24'sd4194304)
        else $error("smoothed level out of range");

    // No input is taken while a tick is in its division steps.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tslfo_pkg::ST_DIV |-> !s_axis_tready)
        else $error("input ready during division");

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tempo-synced LFO
// Sends transport snapshots and sample ticks with random gaps and output
// stalls. It predicts every tick result in a scoreboard and compares each
// output transfer field by field. Several register settings are covered,
// the extreme values among them.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own copy of the oscillator state and registers, and
// a queue of the samples that are still due from the block.
class lfo_sample_board;

    bit [0:0]  sync_on;
    bit [2:0]  division;
    bit [2:0]  shape_sel;
    bit [14:0] free_rate;
    bit [17:0] sample_rate;
    bit [15:0] coef_normal;
    bit [15:0] coef_square;

    longint unsigned beat_pos;
    longint unsigned tempo;
    longint unsigned bar_len;
    bit              transport_usable;
    longint unsigned free_ph;
    longint          level_q22;

    logic [39:0] due_samples[$];
    int unsigned faults;

    function new();
        sync_on = 0; division = 2; shape_sel = 0; free_rate = 1000;
        sample_rate = 48000; coef_normal = 1083; coef_square = 303;
        beat_pos = 0; tempo = 1920; bar_len = 64; transport_usable = 0;
        free_ph = 0; level_q22 = 0; faults = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [17:0] val);
        case (idx)
            tslfo_pkg::CFG_LFO_SYNC:      sync_on     = val[0];
            tslfo_pkg::CFG_RATE_DIVISION: division    = val[2:0];
            tslfo_pkg::CFG_WAVE_SHAPE:    shape_sel   = val[2:0];
            tslfo_pkg::CFG_FREE_RATE:     free_rate   = val[14:0];
            tslfo_pkg::CFG_SAMPLE_RATE:   sample_rate = val[17:0];
            tslfo_pkg::CFG_COEF_NORMAL:   coef_normal = val[15:0];
            tslfo_pkg::CFG_COEF_SQUARE:   coef_square = val[15:0];
            default: ;
        endcase
    endfunction

    // Quarter-wave polynomial in Q28, folded into a full sine in Q1.22.
    function longint sine_level(longint unsigned ph);
        longint unsigned c[5];
        longint unsigned k, f, x, x2, acc, y;
        int unsigned quad;
        c[0] = 421657428; c[1] = 173399667; c[2] = 21392326;
        c[3] = 1256749;   c[4] = 43068;
        k = (ph * 1024) >> 32;
        f = (k << 30) / 1024;
        quad = (f >> 28) & 3;
        x = f & ((64'd1 << 28) - 1);
        if (quad[0])
            x = (64'd1 << 28) - x;
        x2 = (x * x) >> 28;
        acc = c[4];
        for (int i = 3; i >= 0; i--)
            acc = c[i] - ((acc * x2) >> 28);
        y = (((acc * x) >> 28) + 32) >> 6;
        if (y > (64'd1 << 22))
            y = 64'd1 << 22;
        return (quad >= 2) ? -longint'(y) : longint'(y);
    endfunction

    function longint shape_level(bit [2:0] shp, longint unsigned ph);
        longint f, one;
        one = longint'(1) << 22;
        f = longint'(ph >> 10);
        case (shp)
            tslfo_pkg::SHAPE_TRIANGLE: return (f < one / 2) ? 4 * f - one : 3 * one - 4 * f;
            tslfo_pkg::SHAPE_FALLING:  return one - 2 * f;
            tslfo_pkg::SHAPE_RISING:   return 2 * f - one;
            tslfo_pkg::SHAPE_SQUARE:   return (f < one / 2) ? one : -one;
            default:                   return sine_level(ph);
        endcase
    endfunction

    // Cycle length of the selected note division, in 1/96 beat.
    function longint unsigned cycle_len();
        longint unsigned len;
        len = (bar_len < 16) ? 16 : bar_len;
        case (division)
            3'd0: return 6 * len;
            3'd1: return (3 * len < 48) ? 48 : 3 * len;
            3'd2: return 96;
            3'd3: return 48;
            3'd4: return 32;
            3'd5: return 24;
            3'd6: return 16;
            default: return 12;
        endcase
    endfunction

    function void note_input(logic cmd, logic [63:0] data);
        longint unsigned sr, ph, t, d, r, len;
        longint target, coef, bip;
        bit [2:0] shp;
        if (cmd == tslfo_pkg::CMD_TRANSPORT) begin
            if (data[15:2] > 16)
                tempo = data[15:2];
            if (data[25:16] > 0)
                bar_len = data[25:16];
            transport_usable = data[0] && data[1] && data[15:2] > 16 && data[25:16] > 0;
            if (transport_usable) begin
                len = (data[25:16] < 16) ? 16 : data[25:16];
                beat_pos = ((longint'(data[41:26]) * len) << 20)
                           + (longint'(data[63:42]) << 8);
                beat_pos &= (64'd1 << 48) - 1;
            end
            return;
        end
        sr = (sample_rate < 1000) ? 1000 : sample_rate;
        ph = free_ph;
        if (sync_on) begin
            d = cycle_len();
            if (transport_usable)
                ph = (((beat_pos * 96) % (d << 24)) / d << 8) & 32'hFFFF_FFFF;
            t = (tempo < 320) ? 320 : ((tempo > 5120) ? 5120 : tempo);
            beat_pos = (beat_pos + (t << 24) / (960 * sr)) & ((64'd1 << 48) - 1);
            if (!transport_usable)
                free_ph = (free_ph + (t << 32) / (10 * sr * d)) & 32'hFFFF_FFFF;
        end else begin
            r = (free_rate < 50) ? 50 : ((free_rate > 20000) ? 20000 : free_rate);
            free_ph = (free_ph + (r << 32) / (1000 * sr)) & 32'hFFFF_FFFF;
        end
        shp = (shape_sel > 4) ? tslfo_pkg::SHAPE_SQUARE : shape_sel;
        target = shape_level(shp, ph);
        coef = (shp == tslfo_pkg::SHAPE_SQUARE) ? coef_square : coef_normal;
        level_q22 += ((target - level_q22) * coef + 32768) >>> 16;
        bip = (level_q22 + 64) >>> 7;
        if (bip > 32767)
            bip = 32767;
        if (bip < -32768)
            bip = -32768;
        due_samples.push_back({7'd0, sync_on[0] && transport_usable,
                               16'(bip + 32768), 16'(bip)});
    endfunction

    function void check_sample(logic [39:0] got);
        logic [39:0] want;
        if (due_samples.size() == 0) begin
            $display("%0t: unexpected sample %h", $realtime, got);
            faults++;
            return;
        end
        want = due_samples.pop_front();
        if (got[15:0] !== want[15:0]) begin
            $display("%0t: bipolar expected %0d, actual %0d", $realtime,
                     $signed(want[15:0]), $signed(got[15:0]));
            faults++;
        end
        if (got[31:16] !== want[31:16]) begin
            $display("%0t: unipolar expected %0d, actual %0d", $realtime,
                     want[31:16], got[31:16]);
            faults++;
        end
        if (got[32] !== want[32]) begin
            $display("%0t: synced expected %b, actual %b", $realtime, want[32], got[32]);
            faults++;
        end
    endfunction

endclass

module testbench;

    localparam int IDLE_LIMIT  = 20000;  // cycles with no transfer at all
    localparam int SETTLE_WAIT = 200;    // longer than the longest tick

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [17:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata from bit 0: transport_valid, transport_playing, host_bpm[13:0],
    // host_beats_per_bar[9:0], bar_index[15:0], beat_in_bar[21:0]
    logic [63:0] s_axis_tdata = '0;
    // tuser: cmd
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata from bit 0: bipolar_level[15:0], unipolar_level[15:0], synced
    logic [39:0] m_axis_tdata;

    lfo_sample_board board = new();
    bit          calm = 0;       // when set, neither side idles
    int unsigned quiet_cycles = 0;
    int unsigned out_stall = 0;

    tempo_synced_lfo i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // The receiving side stalls at random.
    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                out_stall <= pick_gap();
        end
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_sample(m_axis_tdata);
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] transport_word(bit tv, bit tp, bit [13:0] bpm,
            bit [9:0] bpb, bit [15:0] bar, bit [21:0] beat);
        return {beat, bar, bpb, bpm, tp, tv};
    endfunction

    task automatic send_item(logic cmd, logic [63:0] data);
        int unsigned g;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(cmd, data);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [17:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        board.write_reg(idx, val);
    endtask

    // Registers may change only once the block has gone quiet: a snapshot
    // yields nothing, so the last tick may still be in work.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.due_samples.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic random_item();
        int unsigned r;
        logic [63:0] w;
        r = $urandom_range(0, 99);
        w = {$urandom(), $urandom()};
        if (r >= 22) begin
            send_item(tslfo_pkg::CMD_TICK, w);
        end else if (r >= 4) begin
            // Mostly well-formed snapshots that keep the transport usable.
            send_item(tslfo_pkg::CMD_TRANSPORT, transport_word($urandom_range(0, 15) != 0,
                $urandom_range(0, 15) != 0, $urandom_range(300, 5200),
                $urandom_range(16, 128), w[41:26], w[63:42]));
        end else begin
            send_item(tslfo_pkg::CMD_TRANSPORT, w);
        end
    endtask

    initial begin
        logic [17:0] v;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset settings, then in sync mode.
        send_item(tslfo_pkg::CMD_TICK, '0);
        send_item(tslfo_pkg::CMD_TICK, '1);
        send_item(tslfo_pkg::CMD_TRANSPORT,
                  transport_word(1, 1, 14'd16, 10'd64, 16'd3, 22'd0));
        send_item(tslfo_pkg::CMD_TRANSPORT,
                  transport_word(1, 1, 14'd17, 10'd0, 16'd3, 22'd0));
        send_item(tslfo_pkg::CMD_TRANSPORT,
                  transport_word(0, 1, 14'd0, 10'd1, 16'd0, 22'd1));
        send_item(tslfo_pkg::CMD_TRANSPORT,
                  transport_word(1, 0, 14'h3FFF, 10'd15, 16'hFFFF, 22'h3FFFFF));
        send_item(tslfo_pkg::CMD_TICK, '0);
        send_item(tslfo_pkg::CMD_TRANSPORT,
                  transport_word(1, 1, 14'h3FFF, 10'h3FF, 16'hFFFF, 22'h3FFFFF));
        send_item(tslfo_pkg::CMD_TICK, '0);
        drain();
        write_reg(tslfo_pkg::CFG_LFO_SYNC, 18'd1);
        write_reg(tslfo_pkg::CFG_RATE_DIVISION, 18'd0);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        send_item(tslfo_pkg::CMD_TICK, '0);
        send_item(tslfo_pkg::CMD_TRANSPORT,
                  transport_word(1, 1, 14'd1920, 10'd1, 16'd7, 22'h20000));
        send_item(tslfo_pkg::CMD_TICK, '0);
        send_item(tslfo_pkg::CMD_TICK, '0);
        send_item(tslfo_pkg::CMD_TRANSPORT,
                  transport_word(1, 1, 14'd100, 10'd1023, 16'hFFFF, 22'h3FFFFF));
        send_item(tslfo_pkg::CMD_TICK, '0);
        send_item(tslfo_pkg::CMD_TRANSPORT,
                  transport_word(1, 0, 14'd9000, 10'd48, 16'd1, 22'd5));
        send_item(tslfo_pkg::CMD_TICK, '0);
        send_item(tslfo_pkg::CMD_TICK, '0);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            calm = (ph % 3 == 2);
            for (int i = 0; i < 8; i++) begin
                case (i)
                    tslfo_pkg::CFG_LFO_SYNC:
                        v = (ph == 1 || ph == 2) ? 1 : $urandom_range(0, 1);
                    tslfo_pkg::CFG_RATE_DIVISION:
                        v = (ph == 1) ? 0 : (ph == 2) ? 7 : $urandom_range(0, 7);
                    tslfo_pkg::CFG_WAVE_SHAPE:
                        v = (ph < 8) ? ph : $urandom_range(0, 7);
                    tslfo_pkg::CFG_FREE_RATE:
                        v = (ph == 1) ? 0 : (ph == 2) ? 18'h7FFF
                            : (ph == 3) ? 20000 : $urandom_range(0, 32767);
                    tslfo_pkg::CFG_SAMPLE_RATE:
                        v = (ph == 1) ? 0 : (ph == 2) ? 18'h3FFFF
                            : (ph == 3) ? 1000 : $urandom_range(0, 200000);
                    tslfo_pkg::CFG_COEF_NORMAL,
                    tslfo_pkg::CFG_COEF_SQUARE:
                        v = (ph == 1) ? 0 : (ph == 2) ? 18'hFFFF
                            : $urandom_range(0, 65535);
                    default:
                        v = $urandom();
                endcase
                write_reg(i[2:0], v);
            end
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            repeat (100) random_item();
        end

        drain();
        if (board.due_samples.size() > 0) begin
            $display("%0t: %0d expected samples never arrived", $realtime,
                     board.due_samples.size());
            board.faults++;
        end
        if (board.faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tslfo_pkg.sv
rtl/tempo_synced_lfo.sv
test/testbench.sv
